// ===== rtl/core/sha256_pkg.sv =====
// sha256 package: round constants, initial hash values and round functions
`timescale 1ns / 1ps
package sha256_pkg;

	localparam int unsigned WordW = 32;

	typedef logic [WordW-1:0] word_t;

	// transaction from front to back: one block word plus block end and message end marks
	typedef struct packed {
		word_t        word;
		logic         blk_end;
		logic         msg_end;
	} fifo_ent_t;

	function automatic word_t round_k(input logic [5:0] idx);
		word_t r;
		r = '0;
		unique case (idx)
			6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
			6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
			6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
			6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
			6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
			6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
			6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
			6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
			6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
			6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
			6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
			6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
			6'd63: r = 32'hc67178f2;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic word_t init_h(input logic [2:0] idx);
		word_t r;
		r = '0;
		unique case (idx)
			3'd0: r = 32'h6a09e667; 3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372; 3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f; 3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab; 3'd7: r = 32'h5be0cd19;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (WordW - n));
	endfunction

	function automatic word_t bsig0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction
	function automatic word_t bsig1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction
	function automatic word_t ssig0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction
	function automatic word_t ssig1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ===== rtl/core/sha256_front.sv =====
// sha256 front end: masks input words, counts bits and generates padding
`timescale 1ns / 1ps
module sha256_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [31:0]             data_word,
	input  logic [2:0]              byte_count,
	input  logic                    last_word,
	output logic                    ent_valid,
	input  logic                    ent_ready,
	output sha256_pkg::fifo_ent_t   ent
);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_ZERO = 4'b0010,
		F_LENH = 4'b0100,
		F_LENL = 4'b1000
	} fstate_t;

	fstate_t     state_q;
	logic [3:0]  widx_q;
	logic [63:0] bits_q;
	logic        extra_q;
	logic [2:0]  cnt;
	logic [31:0] masked;
	logic [31:0] padded;
	logic [63:0] bits_next;
	logic        in_acc;
	logic        emit;
	logic [3:0]  widx_next;

	always_comb begin
		cnt = (byte_count > 3'd4 || !last_word) ? 3'd4 : byte_count;
		unique case (cnt)
			3'd0: masked = '0;
			3'd1: masked = {data_word[31:24], 24'h0};
			3'd2: masked = {data_word[31:16], 16'h0};
			3'd3: masked = {data_word[31:8], 8'h0};
			default: masked = data_word;
		endcase
		unique case (cnt)
			3'd0: padded = 32'h8000_0000;
			3'd1: padded = masked | 32'h0080_0000;
			3'd2: padded = masked | 32'h0000_8000;
			3'd3: padded = masked | 32'h0000_0080;
			default: padded = masked;
		endcase
		bits_next = bits_q + {58'd0, cnt, 3'd0};
	end

	assign in_ready = (state_q == F_IDLE) && !extra_q && ent_ready;
	assign in_acc   = in_valid && in_ready;
	assign widx_next = widx_q + 4'd1;

	always_comb begin
		ent_valid = 1'b0;
		ent.word = '0;
		ent.blk_end = (widx_q == 4'd15);
		ent.msg_end = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				if (extra_q) begin
					ent_valid = 1'b1;
					ent.word = 32'h8000_0000;
				end else begin
					ent_valid = in_valid;
					ent.word = last_word ? padded : masked;
				end
			end
			F_ZERO: ent_valid = 1'b1;
			F_LENH: begin
				ent_valid = 1'b1;
				ent.word = bits_q[63:32];
			end
			F_LENL: begin
				ent_valid = 1'b1;
				ent.word = bits_q[31:0];
				ent.msg_end = 1'b1;
			end
			default: ent_valid = 1'b0;
		endcase
	end

	assign emit = ent_valid && ent_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			widx_q <= '0;
			bits_q <= '0;
			extra_q <= 1'b0;
		end else if (emit) begin
			widx_q <= widx_next;
			unique case (state_q)
				F_IDLE: begin
					if (extra_q) begin
						extra_q <= 1'b0;
						state_q <= (widx_next == 4'd14) ? F_LENH : F_ZERO;
					end else if (in_acc) begin
						bits_q <= bits_next;
						if (last_word) begin
							if (cnt == 3'd4) extra_q <= 1'b1;
							else state_q <= (widx_next == 4'd14) ? F_LENH : F_ZERO;
						end
					end
				end
				F_ZERO: if (widx_next == 4'd14) state_q <= F_LENH;
				F_LENH: state_q <= F_LENL;
				F_LENL: begin
					state_q <= F_IDLE;
					bits_q <= '0;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/sha256_fifo.sv =====
// sha256 queue between front and back
`timescale 1ns / 1ps
module sha256_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_valid,
	output logic                   wr_ready,
	input  sha256_pkg::fifo_ent_t  wr_data,
	output logic                   rd_valid,
	input  logic                   rd_ready,
	output sha256_pkg::fifo_ent_t  rd_data
);

	sha256_pkg::fifo_ent_t mem_q [4];
	logic [2:0] wp_q, rp_q;
	logic [2:0] used;

	assign used = wp_q - rp_q;
	assign wr_ready = used != 3'd4;
	assign rd_valid = used != 3'd0;
	assign rd_data = mem_q[rp_q[1:0]];

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) mem_q[wp_q[1:0]] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= wp_q + 3'd1;
			if (rd_valid && rd_ready) rp_q <= rp_q + 3'd1;
		end
	end

endmodule

// ===== rtl/core/sha256_back.sv =====
// sha256 back end: block gathering, 64-round compression and digest output
`timescale 1ns / 1ps
module sha256_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   ent_valid,
	output logic                   ent_ready,
	input  sha256_pkg::fifo_ent_t  ent,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [31:0]            digest_word,
	output logic [2:0]             word_position,
	output logic                   digest_last
);

	typedef enum logic [3:0] {
		B_LOAD = 4'b0001,
		B_RND  = 4'b0010,
		B_ADD  = 4'b0100,
		B_OUT  = 4'b1000
	} bstate_t;

	bstate_t           state_q;
	sha256_pkg::word_t h_q [8];
	sha256_pkg::word_t v_q [8];
	sha256_pkg::word_t w_q [16];
	logic [5:0]        rnd_q;
	logic [2:0]        opos_q;
	logic              msg_end_q;
	sha256_pkg::word_t wt, t1, t2, wnew;

	assign ent_ready = (state_q == B_LOAD);
	assign out_valid = (state_q == B_OUT);
	assign digest_word = h_q[opos_q];
	assign word_position = opos_q;
	assign digest_last = (opos_q == 3'd7);

	// w_q is a shift window: w_q[0] is w[t-16] from round 16 on, and w[t] before
	always_comb begin
		wnew = sha256_pkg::ssig1(w_q[14]) + w_q[9] + sha256_pkg::ssig0(w_q[1]) + w_q[0];
		wt = (rnd_q < 6'd16) ? w_q[0] : wnew;
		t1 = v_q[7] + sha256_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha256_pkg::round_k(rnd_q) + wt;
		t2 = sha256_pkg::bsig0(v_q[0])
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (state_q == B_LOAD && ent_valid) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= ent.word;
			if (ent.blk_end) for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (state_q == B_RND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wt;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_LOAD;
			rnd_q <= '0;
			opos_q <= '0;
			msg_end_q <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::init_h(3'(i));
		end else begin
			unique case (state_q)
				B_LOAD: if (ent_valid && ent.blk_end) begin
					state_q <= B_RND;
					msg_end_q <= ent.msg_end;
					rnd_q <= '0;
				end
				B_RND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= B_ADD;
				end
				B_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					opos_q <= '0;
					state_q <= msg_end_q ? B_OUT : B_LOAD;
				end
				B_OUT: if (out_ready) begin
					opos_q <= opos_q + 3'd1;
					if (opos_q == 3'd7) begin
						state_q <= B_LOAD;
						for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::init_h(3'(i));
					end
				end
				default: state_q <= B_LOAD;
			endcase
		end
	end

endmodule

// ===== rtl/core/sha256_message_hash.sv =====
// sha256 message hash top level
`timescale 1ns / 1ps
// SHA-256 over a stream of big-endian 32-bit words. The front end takes one
// word per cycle, while the queue has room and no extra padding word is pending,
// into a four-entry queue and inserts padding and the length. The back end works
// on one 16-word block at a time: it takes one word a cycle while the queue has
// words until the block is full, runs 64 rounds at one round per cycle, then does
// the hash add, and takes no new words meanwhile. After the last word the eight digest words
// appear in order, most significant first, one per accepted output transaction.
module sha256_message_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_position,
	output logic        digest_last
);

	sha256_pkg::fifo_ent_t f_ent, b_ent;
	logic f_valid, f_ready, b_valid, b_ready;

	sha256_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .data_word, .byte_count, .last_word,
		.ent_valid(f_valid), .ent_ready(f_ready), .ent(f_ent)
	);

	sha256_fifo u_fifo (
		.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_ent),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_ent)
	);

	sha256_back u_back (
		.clk, .arst_n, .ent_valid(b_valid), .ent_ready(b_ready), .ent(b_ent),
		.out_valid, .out_ready, .digest_word, .word_position, .digest_last
	);

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (digest_last == (word_position == 3'd7)))
		else $error("digest_last mismatch");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !digest_last |=> out_valid)
		else $error("digest burst broken");

	a_in_front: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> f_valid && f_ready)
		else $error("input not queued");

endmodule

// ===== test/testbench.sv =====
// testbench for sha256_message_hash: random messages checked against a built-in sha-256 predictor
`timescale 1ns / 1ps
module testbench;
	typedef logic [31:0] word_t;

	typedef struct {
		logic [31:0] data;
		logic [2:0]  nbytes;
		logic        last;
	} msg_word_t;

	typedef struct {
		logic [31:0] digest;
		logic [2:0]  pos;
		logic        last;
	} digest_ent_t;

	localparam int unsigned TimeoutCycles = 2000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        last_word;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_position;
	logic        digest_last;
	logic        in_ready_q;

	msg_word_t   pending_words[$];
	digest_ent_t expected_digests[$];
	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned words_sent;
	int unsigned digests_seen;
	int unsigned messages_sent;
	bit          idle_enable;
	bit          sender_hold;
	int unsigned long_hold;
	int unsigned in_gap;
	int unsigned out_gap;

	// predictor state
	word_t       hash_state[8];
	word_t       block_buf[16];
	int unsigned block_fill;
	logic [63:0] bit_length;

	const word_t k_table[64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
	const word_t h_init[8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	sha256_message_hash uut (.*);

	function automatic word_t ror32(word_t x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic restart_hash();
		for (int i = 0; i < 8; i++) hash_state[i] = h_init[i];
		block_fill = 0;
		bit_length = '0;
	endtask

	task automatic compress_block();
		word_t w[64];
		word_t v[8];
		word_t t1;
		word_t t2;
		for (int t = 0; t < 64; t++) begin
			if (t < 16) begin
				w[t] = block_buf[t];
			end else begin
				w[t] = (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
					+ (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
			end
		end
		for (int i = 0; i < 8; i++) v[i] = hash_state[i];
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_table[t] + w[t];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
	endtask

	task automatic push_block_word(word_t w);
		block_buf[block_fill] = w;
		block_fill++;
		if (block_fill == 16) begin
			compress_block();
			block_fill = 0;
		end
	endtask

	// feeds one accepted word into the predictor, queuing a digest on the last one
	task automatic hash_word(msg_word_t mw);
		int unsigned nb;
		word_t w;
		digest_ent_t d;
		nb = (mw.nbytes > 4 || !mw.last) ? 4 : mw.nbytes;
		w = (nb == 0) ? '0 : mw.data & (32'hffffffff << (8 * (4 - nb)));
		bit_length += 64'(nb * 8);
		if (!mw.last) begin
			push_block_word(w);
		end else begin
			if (nb < 4) begin
				push_block_word(w | (32'h80 << (8 * (3 - nb))));
			end else begin
				push_block_word(w);
				push_block_word(32'h80000000);
			end
			while (block_fill != 14) push_block_word('0);
			push_block_word(bit_length[63:32]);
			push_block_word(bit_length[31:0]);
			for (int i = 0; i < 8; i++) begin
				d.digest = hash_state[i];
				d.pos = 3'(i);
				d.last = (i == 7);
				expected_digests.insert(expected_digests.size(), d);
			end
			restart_hash();
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
		error_count++;
	endtask

	task automatic queue_word(logic [31:0] d, logic [2:0] nb, logic lst);
		msg_word_t mw;
		mw.data = d;
		mw.nbytes = nb;
		mw.last = lst;
		pending_words.insert(pending_words.size(), mw);
	endtask

	task automatic queue_message(int unsigned nwords, logic [2:0] tail_bytes);
		for (int i = 0; i + 1 < nwords; i++) begin
			// non-last words may carry any byte count
			queue_word($urandom, ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'd4, 1'b0);
		end
		queue_word($urandom, tail_bytes, 1'b1);
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || in_valid || expected_digests.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > TimeoutCycles) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TEST FAILED");
			$finish;
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready_q) begin
				if (in_gap != 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_words.size() != 0 && !sender_hold) begin
					data_word <= pending_words[0].data;
					byte_count <= pending_words[0].nbytes;
					last_word <= pending_words[0].last;
					pending_words.delete(0);
					in_valid <= 1'b1;
					if (idle_enable && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 19);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// input acceptance captured at the rising edge
	always @(posedge clk) begin
		in_ready_q <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			hash_word('{data_word, byte_count, last_word});
			words_sent <= words_sent + 1;
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (long_hold != 0) begin
				long_hold <= long_hold - 1;
				out_ready <= 1'b0;
			end else if (out_gap != 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (idle_enable && $urandom_range(0, 7) == 0) out_gap <= $urandom_range(1, 19);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		digest_ent_t want;
		if (arst_n && out_valid && out_ready) begin
			digests_seen <= digests_seen + 1;
			if (expected_digests.size() == 0) begin
				report_mismatch("unexpected digest word", digest_word, '0);
			end else begin
				want = expected_digests[0];
				expected_digests.delete(0);
				if (digest_word !== want.digest)
					report_mismatch("digest_word", digest_word, want.digest);
				if (word_position !== want.pos)
					report_mismatch("word_position", 32'(word_position), 32'(want.pos));
				if (digest_last !== want.last)
					report_mismatch("digest_last", 32'(digest_last), 32'(want.last));
			end
		end
	end

	initial begin
		int unsigned nw;
		int unsigned queued;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_word = '0;
		byte_count = '0;
		last_word = 1'b0;
		out_ready = 1'b0;
		in_ready_q = 1'b0;
		error_count = 0;
		cycle_count = 0;
		words_sent = 0;
		digests_seen = 0;
		messages_sent = 0;
		idle_enable = 1'b0;
		sender_hold = 1'b0;
		long_hold = 0;
		in_gap = 0;
		out_gap = 0;
		restart_hash();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty message, every tail size, all-ones and zero data,
		// oversized byte count, short non-last words, block-boundary lengths
		queue_word(32'hffffffff, 3'd0, 1'b1);
		for (int b = 1; b <= 7; b++) queue_word(32'hffffffff, 3'(b), 1'b1);
		queue_word(32'h00000000, 3'd4, 1'b1);
		queue_word(32'h61626300, 3'd3, 1'b1);
		queue_word(32'h12345678, 3'd1, 1'b0);
		queue_word(32'h9abcdef0, 3'd2, 1'b1);
		queue_message(14, 3'd4);
		queue_message(16, 3'd0);
		messages_sent = 13;
		wait_drained();

		// block fills while outputs are held off
		idle_enable = 1'b1;
		long_hold = 400;
		for (int m = 0; m < 4; m++) queue_message($urandom_range(1, 20), 3'($urandom_range(0, 4)));
		messages_sent += 4;
		wait_drained();

		// one short message, then a full drain
		sender_hold = 1'b1;
		queue_message(3, 3'd2);
		messages_sent++;
		sender_hold = 1'b0;
		wait_drained();

		while (words_sent < 170) begin
			nw = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 17);
			queue_message(nw, 3'($urandom_range(0, 7)));
			messages_sent++;
			wait_drained();
		end

		// final stretch without idling
		idle_enable = 1'b0;
		queued = words_sent;
		while (queued < 210) begin
			nw = $urandom_range(1, 16);
			queue_message(nw, 3'($urandom_range(0, 4)));
			queued += nw;
			messages_sent++;
		end
		wait_drained();
		repeat (200) @(posedge clk);

		$display("covered %0d messages, %0d words, %0d digest words checked",
			messages_sent, words_sent, digests_seen);
		$display("including empty, short-tail, oversized-count and multi-block messages");
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
